>>> rtl/core/sat_pkg.sv
package sat_pkg;

   localparam int ValueWidth = 63;

   localparam logic [2:0] KIND_FIXNUM = 3'd0;
   localparam logic [2:0] KIND_BOOL   = 3'd1;
   localparam logic [2:0] KIND_CHAR   = 3'd2;
   localparam logic [2:0] KIND_NIL    = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;
   localparam logic [2:0] KIND_ERROR  = 3'd5;

   // error_code carried by every word that is not an error
   localparam logic [2:0] CODE_NONE = 3'd0;

   localparam logic [2:0] ERR_DIGIT_EXPECTED = 3'd0;
   localparam logic [2:0] ERR_TOO_LARGE      = 3'd1;
   localparam logic [2:0] ERR_NUM_DELIM      = 3'd2;
   localparam logic [2:0] ERR_BOOL_DELIM     = 3'd3;
   localparam logic [2:0] ERR_LIST_OPEN      = 3'd4;
   localparam logic [2:0] ERR_LIST_BAD       = 3'd5;
   localparam logic [2:0] ERR_CHAR_NAME      = 3'd6;
   localparam logic [2:0] ERR_UNEXPECTED     = 3'd7;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef struct packed {
      logic                  hit;
      logic [2:0]            kind;
      logic [ValueWidth-1:0] value;
      logic [2:0]            code;
   } result_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   // tail of "newline" / "space" after the first letter, zero at the end
   function automatic logic [7:0] name_tail(input logic is_nl, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (is_nl) begin
         unique case (pos)
            3'd0: c = 8'h65;
            3'd1: c = 8'h77;
            3'd2: c = 8'h6C;
            3'd3: c = 8'h69;
            3'd4: c = 8'h6E;
            3'd5: c = 8'h65;
            default: c = 8'h00;
         endcase
      end else begin
         unique case (pos)
            3'd0: c = 8'h70;
            3'd1: c = 8'h61;
            3'd2: c = 8'h63;
            3'd3: c = 8'h65;
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

endpackage

>>> rtl/core/sat_lexer.sv
module sat_lexer #(
   parameter int ACC_BITS = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           byte_in,
   input  logic                 eof,
   input  logic [61:0]          max_mag,
   output sat_pkg::result_type  result
);

   localparam int MagW  = ACC_BITS - 1;
   localparam int ProdW = ACC_BITS + 3;
   localparam int ValW  = sat_pkg::ValueWidth;

   typedef enum logic [3:0] {
      PH_IDLE, PH_NUM, PH_LIST, PH_HASH, PH_BOOL, PH_CHAR1, PH_CHAR2, PH_NAME, PH_HALT
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [MagW-1:0]  acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic             seen_ff, seen_in;
   logic [7:0]       held_ff, held_in;
   logic [2:0]       pos_ff, pos_in;
   logic             boolv_ff, boolv_in;

   logic             digit, ws;
   logic [3:0]       dval;
   logic [MagW-1:0]  acc_base;
   logic [ProdW-1:0] prod;
   logic [61:0]      cap62, lim62;
   logic [MagW-1:0]  lim;
   logic             too_big;
   logic [ValW-1:0]  mag_ext, num_val, fail_val;
   logic [2:0]       pos_cur;
   logic [7:0]       want;

   assign digit    = !eof && (byte_in >= sat_pkg::CH_ZERO) && (byte_in <= sat_pkg::CH_NINE);
   assign ws       = !eof && sat_pkg::is_ws(byte_in);
   assign dval     = 4'(byte_in - sat_pkg::CH_ZERO);
   assign acc_base = (phase_ff == PH_IDLE) ? '0 : acc_ff;
   assign prod     = ProdW'({acc_base, 3'b000}) + ProdW'({acc_base, 1'b0}) + ProdW'(dval);
   assign cap62    = {62{1'b1}} >> (62 - MagW);
   assign lim62    = (max_mag > cap62) ? cap62 : max_mag;
   assign lim      = lim62[MagW-1:0];
   assign too_big  = prod > ProdW'(lim);
   assign mag_ext  = {{(ValW - MagW){1'b0}}, acc_ff};
   assign num_val  = neg_ff ? (ValW'(0) - mag_ext) : mag_ext;
   assign fail_val = eof ? '0 : ValW'(byte_in);
   assign pos_cur  = (phase_ff == PH_CHAR2) ? 3'd0 : pos_ff;
   assign want     = sat_pkg::name_tail(held_ff == sat_pkg::CH_N, pos_cur);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      held_in  = held_ff;
      pos_in   = pos_ff;
      boolv_in = boolv_ff;
      result   = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (eof) begin
               result.hit  = 1'b1;
               result.kind = sat_pkg::KIND_END;
            end else if (ws) begin
               phase_in = PH_IDLE;
            end else if (digit) begin
               neg_in = 1'b0;
               if (too_big) begin
                  result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_TOO_LARGE};
                  phase_in = PH_HALT;
               end else begin
                  acc_in   = prod[MagW-1:0];
                  seen_in  = 1'b1;
                  phase_in = PH_NUM;
               end
            end else if (byte_in == sat_pkg::CH_PLUS || byte_in == sat_pkg::CH_MINUS) begin
               acc_in   = '0;
               seen_in  = 1'b0;
               neg_in   = (byte_in == sat_pkg::CH_MINUS);
               phase_in = PH_NUM;
            end else if (byte_in == sat_pkg::CH_LPAREN) begin
               phase_in = PH_LIST;
            end else if (byte_in == sat_pkg::CH_HASH) begin
               phase_in = PH_HASH;
            end else begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_UNEXPECTED};
               phase_in = PH_HALT;
            end
         end
         PH_NUM: begin
            if (digit) begin
               if (too_big) begin
                  result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_TOO_LARGE};
                  phase_in = PH_HALT;
               end else begin
                  acc_in  = prod[MagW-1:0];
                  seen_in = 1'b1;
               end
            end else if (!seen_ff) begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_DIGIT_EXPECTED};
               phase_in = PH_HALT;
            end else if (ws) begin
               result = '{1'b1, sat_pkg::KIND_FIXNUM, num_val, sat_pkg::CODE_NONE};
               phase_in = PH_IDLE;
            end else begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_NUM_DELIM};
               phase_in = PH_HALT;
            end
         end
         PH_LIST: begin
            if (eof) begin
               result = '{1'b1, sat_pkg::KIND_ERROR, '0, sat_pkg::ERR_LIST_OPEN};
               phase_in = PH_HALT;
            end else if (ws) begin
               phase_in = PH_LIST;
            end else if (byte_in == sat_pkg::CH_RPAREN) begin
               result = '{1'b1, sat_pkg::KIND_NIL, '0, sat_pkg::CODE_NONE};
               phase_in = PH_IDLE;
            end else begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_LIST_BAD};
               phase_in = PH_HALT;
            end
         end
         PH_HASH: begin
            if (!eof && (byte_in == sat_pkg::CH_T || byte_in == sat_pkg::CH_F)) begin
               boolv_in = (byte_in == sat_pkg::CH_T);
               phase_in = PH_BOOL;
            end else if (!eof && byte_in == sat_pkg::CH_BSLASH) begin
               phase_in = PH_CHAR1;
            end else begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_UNEXPECTED};
               phase_in = PH_HALT;
            end
         end
         PH_BOOL: begin
            if (ws) begin
               result = '{1'b1, sat_pkg::KIND_BOOL, ValW'(boolv_ff), sat_pkg::CODE_NONE};
               phase_in = PH_IDLE;
            end else begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_BOOL_DELIM};
               phase_in = PH_HALT;
            end
         end
         PH_CHAR1: begin
            if (eof) begin
               result = '{1'b1, sat_pkg::KIND_ERROR, '0, sat_pkg::ERR_CHAR_NAME};
               phase_in = PH_HALT;
            end else begin
               held_in  = byte_in;
               phase_in = PH_CHAR2;
            end
         end
         PH_CHAR2, PH_NAME: begin
            if (phase_ff == PH_CHAR2 && ws) begin
               result = '{1'b1, sat_pkg::KIND_CHAR, ValW'(held_ff), sat_pkg::CODE_NONE};
               phase_in = PH_IDLE;
            end else if (phase_ff == PH_CHAR2 &&
                         held_ff != sat_pkg::CH_N && held_ff != sat_pkg::CH_S) begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_CHAR_NAME};
               phase_in = PH_HALT;
            end else if (want != 8'h00) begin
               if (!eof && byte_in == want) begin
                  pos_in   = pos_cur + 3'd1;
                  phase_in = PH_NAME;
               end else begin
                  result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_CHAR_NAME};
                  phase_in = PH_HALT;
               end
            end else if (ws) begin
               result = '{1'b1, sat_pkg::KIND_CHAR,
                          (held_ff == sat_pkg::CH_N) ? ValW'(sat_pkg::CH_NL)
                                                     : ValW'(sat_pkg::CH_SPACE),
                          sat_pkg::CODE_NONE};
               phase_in = PH_IDLE;
            end else begin
               result = '{1'b1, sat_pkg::KIND_ERROR, fail_val, sat_pkg::ERR_CHAR_NAME};
               phase_in = PH_HALT;
            end
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         held_ff  <= '0;
         pos_ff   <= '0;
         boolv_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         seen_ff  <= seen_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         boolv_ff <= boolv_in;
      end
   end

endmodule

>>> rtl/core/scheme_atom_tokenizer_top.sv
// A word waits in the input register; any token it yields is registered before rsp_.
// Throughput: one req word per cycle; the lexer state updates once per word.
// req_tready drops only while the held input word waits on a stalled rsp_ word.
// Synchronous active-high reset returns the lexer to idle, empties both
// registers and sets max_magnitude to 2^62-1.
module scheme_atom_tokenizer_top #(
   parameter int ACC_BITS = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // byte_in
   input  logic [0:0]  req_tuser,  // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // token_value[62:0], error_code[65:63], zero pad
   output logic [2:0]  rsp_tuser,  // token_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [61:0] csr_data    // max_magnitude
);

   logic                in_v_ff, in_v_in;
   logic [7:0]          in_byte_ff;
   logic                in_eof_ff;
   logic                out_v_ff, out_v_in;
   logic [2:0]          out_kind_ff;
   logic [62:0]         out_value_ff;
   logic [2:0]          out_code_ff;
   logic [61:0]         max_mag_ff;
   logic                fire;
   logic                req_take;
   sat_pkg::result_type result;

   assign fire       = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || fire;
   assign req_take   = req_tvalid && req_tready;
   assign in_v_in    = req_take || (in_v_ff && !fire);
   assign out_v_in   = fire ? result.hit : (out_v_ff && !rsp_tready);
   assign csr_ready  = 1'b1;

   sat_lexer #(
      .ACC_BITS(ACC_BITS)
   ) u_lexer (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .byte_in(in_byte_ff),
      .eof    (in_eof_ff),
      .max_mag(max_mag_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
         max_mag_ff <= {62{1'b1}};
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         if (csr_valid && csr_ready) begin
            max_mag_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tuser[0];
      end
      if (fire && result.hit) begin
         out_kind_ff  <= result.kind;
         out_value_ff <= result.value;
         out_code_ff  <= result.code;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {6'b0, out_code_ff, out_value_ff};

endmodule

>>> rtl/core/sat_checker.sv
module sat_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word right after reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == sat_pkg::KIND_ERROR |=> !rsp_tvalid)
      else $error("word after error");

   a_code_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != sat_pkg::KIND_ERROR
      |-> rsp_tdata[65:63] == sat_pkg::CODE_NONE)
      else $error("error code on non-error word");

   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == sat_pkg::KIND_NIL || rsp_tuser == sat_pkg::KIND_END)
      |-> rsp_tdata[62:0] == 63'd0)
      else $error("value on nil or end word");

endmodule

bind scheme_atom_tokenizer_top sat_checker u_sat_checker (.*);
